// File: rtl/rata_pkg.sv
package rata_pkg;

  localparam int unsigned ACC_W      = 64;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned SUM_W      = 8;   // byte count plus phy header
  localparam int unsigned MUL_A_W    = 12;
  localparam int unsigned MUL_B_W    = 10;
  localparam int unsigned MUL_W      = MUL_A_W + MUL_B_W;
  localparam int unsigned TMP_W      = 12;  // bytes times symbols per octet
  localparam int unsigned FRAME_W    = 20;
  localparam int unsigned ACK_W      = 18;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  // event kinds
  localparam logic [2:0] KIND_STATUS   = 3'd0;
  localparam logic [2:0] KIND_TX_DONE  = 3'd1;
  localparam logic [2:0] KIND_RX_DONE  = 3'd2;
  localparam logic [2:0] KIND_TIMED_RX = 3'd3;
  localparam logic [2:0] KIND_READ     = 3'd4;
  localparam logic [2:0] KIND_RESET    = 3'd5;

  // radio status codes
  localparam logic [1:0] ST_DISABLED = 2'd0;
  localparam logic [1:0] ST_SLEEP    = 2'd1;
  localparam logic [1:0] ST_RECEIVE  = 2'd2;
  localparam logic [1:0] ST_SPARE    = 2'd3;  // kept as given, credits nothing

  // completion result codes
  localparam logic [1:0] RES_SUCCESS = 2'd0;
  localparam logic [1:0] RES_NO_ACK  = 2'd1;

  // accumulator slots
  localparam logic [1:0] ACC_TX    = 2'd0;
  localparam logic [1:0] ACC_RX    = 2'd1;
  localparam logic [1:0] ACC_SLEEP = 2'd2;
  localparam logic [1:0] ACC_DIS   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_PHY_HDR   = 3'd0;
  localparam logic [2:0] REG_SYM_OCTET = 3'd1;
  localparam logic [2:0] REG_SYM_TIME  = 3'd2;
  localparam logic [2:0] REG_US_BYTE   = 3'd3;
  localparam logic [2:0] REG_ACK_BYTES = 3'd4;

  // register reset values
  localparam logic [3:0] RST_PHY_HDR   = 4'd6;
  localparam logic [3:0] RST_SYM_OCTET = 4'd2;
  localparam logic [7:0] RST_SYM_TIME  = 8'd16;
  localparam logic [9:0] RST_US_BYTE   = 10'd32;
  localparam logic [6:0] RST_ACK_BYTES = 7'd5;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB_CLAMP
  } alu_op_t;

  typedef struct packed {
    logic [3:0] phy_header_bytes;
    logic [3:0] symbols_per_octet;
    logic [7:0] symbol_time_us;
    logic [9:0] us_per_byte;
    logic [6:0] ack_frame_bytes;
  } cfg_t;

endpackage

// File: rtl/rata_cfg.sv
module rata_cfg
  import rata_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [2:0] idx;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phy_header_bytes  <= RST_PHY_HDR;
      cfg.symbols_per_octet <= RST_SYM_OCTET;
      cfg.symbol_time_us    <= RST_SYM_TIME;
      cfg.us_per_byte       <= RST_US_BYTE;
      cfg.ack_frame_bytes   <= RST_ACK_BYTES;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_PHY_HDR:   cfg.phy_header_bytes  <= pwdata[3:0];
        REG_SYM_OCTET: cfg.symbols_per_octet <= pwdata[3:0];
        REG_SYM_TIME:  cfg.symbol_time_us    <= pwdata[7:0];
        REG_US_BYTE:   cfg.us_per_byte       <= pwdata[9:0];
        REG_ACK_BYTES: cfg.ack_frame_bytes   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PHY_HDR:   prdata = {28'b0, cfg.phy_header_bytes};
      REG_SYM_OCTET: prdata = {28'b0, cfg.symbols_per_octet};
      REG_SYM_TIME:  prdata = {24'b0, cfg.symbol_time_us};
      REG_US_BYTE:   prdata = {22'b0, cfg.us_per_byte};
      REG_ACK_BYTES: prdata = {25'b0, cfg.ack_frame_bytes};
      default:       prdata = '0;
    endcase
  end

endmodule

// File: rtl/rata_mul.sv
module rata_mul
  import rata_pkg::*;
(
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_W-1:0]   p
);

  assign p = {{(MUL_W-MUL_A_W){1'b0}}, a} * {{(MUL_W-MUL_B_W){1'b0}}, b};

endmodule

// File: rtl/rata_alu.sv
module rata_alu
  import rata_pkg::*;
(
  input  alu_op_t           op,
  input  logic [ACC_W-1:0]  a,
  input  logic [TIME_W-1:0] b,
  output logic [ACC_W-1:0]  y
);

  logic [ACC_W:0] diff;

  // borrow out means b exceeded a: clamp at zero
  assign diff = {1'b0, a} - {{(ACC_W-TIME_W+1){1'b0}}, b};

  always_comb begin
    case (op)
      ALU_ADD:       y = a + {{(ACC_W-TIME_W){1'b0}}, b};
      ALU_SUB_CLAMP: y = diff[ACC_W] ? '0 : diff[ACC_W-1:0];
      default:       y = a;
    endcase
  end

endmodule

// File: rtl/radio_activity_time_accounting_core.sv
// radio activity time accounting core
//
// keeps transmit, receive, sleep and disabled time totals (64 bits each)
// from a stream of radio events, each stamped with the microsecond timer.
// input channel: in_valid/in_stall carries one event transaction (kind,
// now_us, new_status, result_code, frame_length, receive_duration_us).
// output channel: out_valid/out_stall carries one transaction per event
// with all four totals after the event has been applied.
// configuration: apb-style port, pready tied high, five registers at byte
// addresses 0..16, user must write only while the block is idle (unenforced).
//
// sequencing: one event at a time through a small sequencer that drives one
// shared 64-bit add / clamped-subtract unit and one 12x10 multiplier.
// completed tx/rx events run the elapsed-time credit, three airtime multiplies
// (the first alongside the credit) and four accumulator steps before the
// result is registered; all other events go from the credit to the result.
// reset (rst, synchronous) clears all totals, status and timestamp and
// restores register defaults. a stalled result is held in the output
// register; the block finishes the next event and then waits for it.
module radio_activity_time_accounting_core
  import rata_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // event input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            kind,
  input  logic [TIME_W-1:0]     now_us,
  input  logic [1:0]            new_status,
  input  logic [1:0]            result_code,
  input  logic [LEN_W-1:0]      frame_length,
  input  logic [TIME_W-1:0]     receive_duration_us,
  // totals output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ACC_W-1:0]      tx_time_total,
  output logic [ACC_W-1:0]      rx_time_total,
  output logic [ACC_W-1:0]      sleep_time_total,
  output logic [ACC_W-1:0]      disabled_time_total,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CREDIT,
    S_MUL_FRAME,
    S_MUL_ACK,
    S_OP0,
    S_OP1,
    S_OP2,
    S_OP3,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SRC_EVENT,
    SRC_FRAME,
    SRC_ACK
  } src_t;

  typedef struct packed {
    logic       en;
    logic [1:0] acc;
    alu_op_t    op;
    src_t       src;
  } alu_req_t;

  state_t state;
  cfg_t   cfg;

  // latched event
  logic [2:0]       ev_kind;
  logic [1:0]       ev_status;
  logic [1:0]       ev_code;
  logic [LEN_W-1:0] ev_len;
  logic [TIME_W-1:0] ev_now;
  logic [TIME_W-1:0] opnd;   // elapsed time, or window length for timed receive

  // radio state
  logic [1:0]        status;
  logic [TIME_W-1:0] last_us;
  logic [ACC_W-1:0]  acc [4];

  // airtimes
  logic [TMP_W-1:0]   tmp;
  logic [FRAME_W-1:0] frame;
  logic [ACK_W-1:0]   ack;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_W-1:0]   mul_p;
  logic [SUM_W-1:0]   frame_bytes;
  logic [SUM_W-1:0]   ack_bytes;

  alu_req_t          req;
  logic [ACC_W-1:0]  alu_a;
  logic [TIME_W-1:0] alu_b;
  logic [ACC_W-1:0]  alu_y;

  logic tx_ok;
  logic rx_ok;
  logic credit_ev;
  logic [1:0] credit_acc;

  rata_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // completions that count: tx on success or no ack, rx on success
  assign tx_ok = (ev_kind == KIND_TX_DONE) &&
                 ((ev_code == RES_SUCCESS) || (ev_code == RES_NO_ACK));
  assign rx_ok = (ev_kind == KIND_RX_DONE) && (ev_code == RES_SUCCESS);
  assign credit_ev = (ev_kind == KIND_STATUS) || (ev_kind == KIND_READ) || tx_ok || rx_ok;

  always_comb begin
    case (status)
      ST_SLEEP:    credit_acc = ACC_SLEEP;
      ST_RECEIVE:  credit_acc = ACC_RX;
      default:     credit_acc = ACC_DIS;
    endcase
  end

  // multiplier operand selection per sequencer step
  assign frame_bytes = {1'b0, ev_len} + {{(SUM_W-4){1'b0}}, cfg.phy_header_bytes};
  assign ack_bytes   = {1'b0, cfg.ack_frame_bytes} + {{(SUM_W-4){1'b0}}, cfg.phy_header_bytes};

  always_comb begin
    case (state)
      S_CREDIT: begin
        mul_a = {{(MUL_A_W-SUM_W){1'b0}}, frame_bytes};
        mul_b = {{(MUL_B_W-4){1'b0}}, cfg.symbols_per_octet};
      end
      S_MUL_FRAME: begin
        mul_a = tmp;
        mul_b = {{(MUL_B_W-8){1'b0}}, cfg.symbol_time_us};
      end
      default: begin
        mul_a = {{(MUL_A_W-SUM_W){1'b0}}, ack_bytes};
        mul_b = cfg.us_per_byte;
      end
    endcase
  end

  rata_mul u_mul (
    .a (mul_a),
    .b (mul_b),
    .p (mul_p)
  );

  // accumulator step for the current sequencer state
  always_comb begin
    req = '{en: 1'b0, acc: ACC_TX, op: ALU_ADD, src: SRC_EVENT};
    case (state)
      S_CREDIT: begin
        if (ev_kind == KIND_TIMED_RX) begin
          if (status == ST_SLEEP) begin
            req = '{en: 1'b1, acc: ACC_RX, op: ALU_ADD, src: SRC_EVENT};
          end
        end else if (credit_ev && (status != ST_SPARE)) begin
          // status three credits nothing
          req = '{en: 1'b1, acc: credit_acc, op: ALU_ADD, src: SRC_EVENT};
        end
      end
      S_OP0: begin
        if (tx_ok) begin
          req = '{en: 1'b1, acc: ACC_TX, op: ALU_ADD, src: SRC_FRAME};
        end else if (rx_ok) begin
          req = '{en: 1'b1, acc: ACC_TX, op: ALU_ADD, src: SRC_ACK};
        end
      end
      S_OP1: begin
        if (tx_ok && (status == ST_RECEIVE)) begin
          req = '{en: 1'b1, acc: ACC_RX, op: ALU_SUB_CLAMP, src: SRC_FRAME};
        end else if (tx_ok && (status == ST_SLEEP)) begin
          req = '{en: 1'b1, acc: ACC_SLEEP, op: ALU_SUB_CLAMP, src: SRC_FRAME};
        end else if (rx_ok && (status == ST_RECEIVE)) begin
          req = '{en: 1'b1, acc: ACC_RX, op: ALU_SUB_CLAMP, src: SRC_ACK};
        end
      end
      S_OP2: begin
        // acked transmit from sleep: ack time moves from sleep to receive
        if (tx_ok && (ev_code == RES_SUCCESS) && (status == ST_SLEEP)) begin
          req = '{en: 1'b1, acc: ACC_RX, op: ALU_ADD, src: SRC_ACK};
        end
      end
      S_OP3: begin
        if (tx_ok && (ev_code == RES_SUCCESS) && (status == ST_SLEEP)) begin
          req = '{en: 1'b1, acc: ACC_SLEEP, op: ALU_SUB_CLAMP, src: SRC_ACK};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (req.src)
      SRC_FRAME: alu_b = {{(TIME_W-FRAME_W){1'b0}}, frame};
      SRC_ACK:   alu_b = {{(TIME_W-ACK_W){1'b0}}, ack};
      default:   alu_b = opnd;
    endcase
  end

  assign alu_a = acc[req.acc];

  rata_alu u_alu (
    .op (req.op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      status    <= ST_DISABLED;
      last_us   <= '0;
      for (int i = 0; i < 4; i++) begin
        acc[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (req.en) begin
        acc[req.acc] <= alu_y;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ev_kind   <= kind;
            ev_status <= new_status;
            ev_code   <= result_code;
            ev_len    <= frame_length;
            ev_now    <= now_us;
            // wrapping 32-bit elapsed time since the last update
            opnd   <= (kind == KIND_TIMED_RX) ? receive_duration_us : now_us - last_us;
            state  <= S_CREDIT;
          end
        end
        S_CREDIT: begin
          tmp <= mul_p[TMP_W-1:0];
          if (credit_ev) begin
            last_us <= ev_now;
          end
          if (ev_kind == KIND_STATUS) begin
            status <= ev_status;
          end
          if (ev_kind == KIND_RESET) begin
            for (int i = 0; i < 4; i++) begin
              acc[i] <= '0;
            end
            last_us <= ev_now;
          end
          state <= (tx_ok || rx_ok) ? S_MUL_FRAME : S_DONE;
        end
        S_MUL_FRAME: begin
          frame <= mul_p[FRAME_W-1:0];
          state <= S_MUL_ACK;
        end
        S_MUL_ACK: begin
          ack   <= mul_p[ACK_W-1:0];
          state <= S_OP0;
        end
        S_OP0: state <= S_OP1;
        S_OP1: state <= S_OP2;
        S_OP2: state <= S_OP3;
        S_OP3: state <= S_DONE;
        S_DONE: begin
          // wait for the output register to be free
          if (!out_valid || !out_stall) begin
            out_valid           <= 1'b1;
            tx_time_total       <= acc[ACC_TX];
            rx_time_total       <= acc[ACC_RX];
            sleep_time_total    <= acc[ACC_SLEEP];
            disabled_time_total <= acc[ACC_DIS];
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/rata_checker.sv
module rata_checker
  import rata_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [ACC_W-1:0] tx_time_total,
  input logic [ACC_W-1:0] disabled_time_total
);

  // one event at a time: busy right after an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous event in flight");

  // a result only appears at the end of event processing
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an event in progress");

  // reset leaves no pending result
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(tx_time_total) && $stable(disabled_time_total)))
    else $error("stalled result changed");

endmodule

bind radio_activity_time_accounting_core rata_checker u_rata_checker (
  .clk                 (clk),
  .rst                 (rst),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .tx_time_total       (tx_time_total),
  .disabled_time_total (disabled_time_total)
);
